// ----- sv/bdq_pkg.sv -----
// bdq_pkg: command codes and controller/datapath interface structs for the
// bounded deque unit. No dependencies; used by every other file.
package bdq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned PCNT_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT   = 4'd0,
        CMD_ADD_BACK    = 4'd1,
        CMD_DROP_FRONT  = 4'd2,
        CMD_DROP_BACK   = 4'd3,
        CMD_CLEAR       = 4'd4,
        CMD_DELETE      = 4'd5,
        CMD_PRINT_ALL   = 4'd6,
        CMD_PRINT_FIRST = 4'd7,
        CMD_PRINT_LAST  = 4'd8
    } t_cmd;

    // controller -> datapath
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic clear_q;
        logic srch_setup;
        logic print_setup;
        logic rd_next;
        logic shift_wr;
        logic dec_count;
        logic ld_elem;
        logic ld_flag;
        logic flag_ovf;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic n_zero;
        logic match;
        logic more;
        logic print_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- sv/bounded_deque_with_delete_by_value_unit.sv -----
// Bounded deque with delete-by-value: top level joining bdq_ctrl and
// bdq_datapath. Depends on bdq_pkg.
//
// Usage: one command item enters on the input channel (i_in_valid/o_in_stall)
// with i_cmd, i_item_value and i_print_count. Results leave on the output
// channel (o_out_valid/i_out_stall) from a single output register.
// Adds, drops, clear and unknown codes give no result; the next item is
// taken in the following cycle. An add to a full store, or a print with
// nothing to show, gives one flagged result from ST_RES once the output
// register is free. A print reads its first element into the read register,
// then loads the output one element per cycle; the run holds up to CAPACITY
// results, the last carrying o_run_last. A delete walks the store one read
// per cycle and closes the gap one write per cycle. The single read port of
// the element store sets these figures. The input is stalled for as long
// as a multi-cycle command runs. When the receiver stalls, the output
// register holds its result and a print run pauses with it. Reset empties
// the deque and the output register; the store contents are not cleared and
// no clearing pass is needed.
module bounded_deque_with_delete_by_value_unit #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [bdq_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [bdq_pkg::VALUE_W-1:0]  i_item_value,
    input  logic [bdq_pkg::PCNT_W-1:0]          i_print_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [bdq_pkg::VALUE_W-1:0]  o_out_value,
    output logic                                o_run_last,
    output logic                                o_no_element,
    output logic                                o_overflow
);

    bdq_pkg::t_dp_cmd dp_cmd;
    bdq_pkg::t_dp_sts dp_sts;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_dp_sts   (dp_sts),
        .o_dp_cmd   (dp_cmd)
    );

    bdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_dp_sts      (dp_sts),
        .i_cmd         (i_cmd),
        .i_item_value  (i_item_value),
        .i_print_count (i_print_count),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_value   (o_out_value),
        .o_run_last    (o_run_last),
        .o_no_element  (o_no_element),
        .o_overflow    (o_overflow)
    );

endmodule

// ----- sv/bdq_datapath.sv -----
// bdq_datapath: circular element store, front/count registers, walk pointer
// and output register. Depends on bdq_pkg.
module bdq_datapath #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bdq_pkg::t_dp_cmd                    i_dp_cmd,
    output bdq_pkg::t_dp_sts                    o_dp_sts,
    input  logic [bdq_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [bdq_pkg::VALUE_W-1:0]  i_item_value,
    input  logic [bdq_pkg::PCNT_W-1:0]          i_print_count,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [bdq_pkg::VALUE_W-1:0]  o_out_value,
    output logic                                o_run_last,
    output logic                                o_no_element,
    output logic                                o_overflow
);

    localparam int unsigned IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNTW = $clog2(CAPACITY + 1);
    localparam int unsigned MW   = (CNTW > bdq_pkg::PCNT_W) ? CNTW : bdq_pkg::PCNT_W;

    logic [bdq_pkg::VALUE_W-1:0] r_mem [CAPACITY];
    logic [bdq_pkg::VALUE_W-1:0] r_rdata;
    logic [bdq_pkg::VALUE_W-1:0] r_key;

    logic [IDXW-1:0] r_front, n_front;
    logic [CNTW-1:0] r_count, n_count;
    logic [CNTW-1:0] r_pos, n_pos;
    logic [CNTW-1:0] r_end, n_end;

    logic                               r_out_valid;
    logic signed [bdq_pkg::VALUE_W-1:0] r_out_value;
    logic                               r_out_last;
    logic                               r_out_none;
    logic                               r_out_ovf;

    logic [IDXW-1:0] front_dec, front_inc;
    logic [CNTW-1:0] n_eff, pr_start, pos_inc;
    logic [MW-1:0]   pc_ext, cnt_ext;
    logic            is_print;

    logic                        wr_en, rd_en, out_free;
    logic [IDXW-1:0]             wr_addr, rd_addr;
    logic [bdq_pkg::VALUE_W-1:0] wr_data;

    // physical index of logical position pos; front < CAPACITY, pos <= CAPACITY
    function automatic logic [IDXW-1:0] slot(input logic [IDXW-1:0] front,
                                             input logic [CNTW-1:0] pos);
        logic [CNTW:0] s;
        s = (CNTW+1)'(front) + (CNTW+1)'(pos);
        if (s >= (CNTW+1)'(CAPACITY)) begin
            s = s - (CNTW+1)'(CAPACITY);
        end
        return s[IDXW-1:0];
    endfunction

    assign front_dec = (r_front == '0) ? IDXW'(CAPACITY - 1) : r_front - 1'b1;
    assign front_inc = (r_front == IDXW'(CAPACITY - 1)) ? '0 : r_front + 1'b1;
    assign pos_inc   = r_pos + 1'b1;

    // clamped print length for the command on the input port
    assign pc_ext  = MW'(i_print_count);
    assign cnt_ext = MW'(r_count);
    always_comb begin
        if (i_cmd == bdq_pkg::CMD_PRINT_ALL || pc_ext > cnt_ext) begin
            n_eff = r_count;
        end else begin
            n_eff = CNTW'(pc_ext);
        end
    end
    assign pr_start = (i_cmd == bdq_pkg::CMD_PRINT_LAST) ? r_count - n_eff : '0;
    assign is_print = i_cmd inside {bdq_pkg::CMD_PRINT_ALL, bdq_pkg::CMD_PRINT_FIRST,
                                    bdq_pkg::CMD_PRINT_LAST};

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_dp_sts.full       = (r_count == CNTW'(CAPACITY));
    assign o_dp_sts.empty      = (r_count == '0);
    assign o_dp_sts.n_zero     = is_print && (n_eff == '0);
    assign o_dp_sts.match      = (r_rdata == r_key);
    assign o_dp_sts.more       = (pos_inc < r_count);
    assign o_dp_sts.print_last = (pos_inc == r_end);
    assign o_dp_sts.out_free   = out_free;

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_pos   = r_pos;
        n_end   = r_end;
        if (i_dp_cmd.clear_q) begin
            n_front = '0;
            n_count = '0;
        end
        if (i_dp_cmd.push_front) begin
            n_front = front_dec;
            n_count = r_count + 1'b1;
        end
        if (i_dp_cmd.push_back) begin
            n_count = r_count + 1'b1;
        end
        if (i_dp_cmd.pop_front) begin
            n_front = front_inc;
            n_count = r_count - 1'b1;
        end
        if (i_dp_cmd.pop_back || i_dp_cmd.dec_count) begin
            n_count = r_count - 1'b1;
        end
        if (i_dp_cmd.print_setup) begin
            n_pos = pr_start;
            n_end = pr_start + n_eff;
        end
        if (i_dp_cmd.srch_setup) begin
            n_pos = '0;
        end
        if (i_dp_cmd.rd_next) begin
            n_pos = pos_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_pos   <= '0;
            r_end   <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_end   <= n_end;
        end
    end

    // store ports: one write, one registered read
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot(r_front, r_count);
        wr_data = i_item_value;
        if (i_dp_cmd.push_front) begin
            wr_en   = 1'b1;
            wr_addr = front_dec;
        end else if (i_dp_cmd.push_back) begin
            wr_en   = 1'b1;
        end else if (i_dp_cmd.shift_wr) begin
            // close the gap: element at r_pos moves down one place
            wr_en   = 1'b1;
            wr_addr = slot(r_front, r_pos - 1'b1);
            wr_data = r_rdata;
        end
    end

    assign rd_en = i_dp_cmd.print_setup | i_dp_cmd.srch_setup | i_dp_cmd.rd_next;

    always_comb begin
        if (i_dp_cmd.print_setup) begin
            rd_addr = slot(r_front, pr_start);
        end else if (i_dp_cmd.srch_setup) begin
            rd_addr = r_front;
        end else begin
            rd_addr = slot(r_front, pos_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (i_dp_cmd.srch_setup) begin
            r_key <= i_item_value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.ld_elem || i_dp_cmd.ld_flag) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.ld_elem) begin
            r_out_value <= r_rdata;
            r_out_last  <= (pos_inc == r_end);
            r_out_none  <= 1'b0;
            r_out_ovf   <= 1'b0;
        end else if (i_dp_cmd.ld_flag) begin
            r_out_value <= '0;
            r_out_last  <= 1'b1;
            r_out_none  <= 1'b1;
            r_out_ovf   <= i_dp_cmd.flag_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_run_last   = r_out_last;
    assign o_no_element = r_out_none;
    assign o_overflow   = r_out_ovf;

endmodule

// ----- sv/bdq_ctrl.sv -----
// bdq_ctrl: command sequencer for the deque; decodes the item and steps the
// datapath through searches, gap closing and print runs. Depends on bdq_pkg.
module bdq_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [bdq_pkg::CMD_W-1:0] i_cmd,
    input  bdq_pkg::t_dp_sts          i_dp_sts,
    output bdq_pkg::t_dp_cmd          o_dp_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RES   = 5'b00010,
        ST_PRINT = 5'b00100,
        ST_SCHK  = 5'b01000,
        ST_SHIFT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovf, n_ovf;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ovf    = r_ovf;
        o_dp_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        bdq_pkg::CMD_ADD_FRONT, bdq_pkg::CMD_ADD_BACK: begin
                            if (i_dp_sts.full) begin
                                n_ovf   = 1'b1;
                                n_state = ST_RES;
                            end else if (i_cmd == bdq_pkg::CMD_ADD_FRONT) begin
                                o_dp_cmd.push_front = 1'b1;
                            end else begin
                                o_dp_cmd.push_back = 1'b1;
                            end
                        end
                        bdq_pkg::CMD_DROP_FRONT: begin
                            o_dp_cmd.pop_front = !i_dp_sts.empty;
                        end
                        bdq_pkg::CMD_DROP_BACK: begin
                            o_dp_cmd.pop_back = !i_dp_sts.empty;
                        end
                        bdq_pkg::CMD_CLEAR: begin
                            o_dp_cmd.clear_q = 1'b1;
                        end
                        bdq_pkg::CMD_DELETE: begin
                            if (!i_dp_sts.empty) begin
                                o_dp_cmd.srch_setup = 1'b1;
                                n_state             = ST_SCHK;
                            end
                        end
                        bdq_pkg::CMD_PRINT_ALL, bdq_pkg::CMD_PRINT_FIRST,
                        bdq_pkg::CMD_PRINT_LAST: begin
                            if (i_dp_sts.n_zero) begin
                                n_ovf   = 1'b0;
                                n_state = ST_RES;
                            end else begin
                                o_dp_cmd.print_setup = 1'b1;
                                n_state              = ST_PRINT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RES: begin
                if (i_dp_sts.out_free) begin
                    o_dp_cmd.ld_flag  = 1'b1;
                    o_dp_cmd.flag_ovf = r_ovf;
                    n_state           = ST_IDLE;
                end
            end
            ST_PRINT: begin
                // the next read is issued only as the current element leaves
                if (i_dp_sts.out_free) begin
                    o_dp_cmd.ld_elem = 1'b1;
                    if (i_dp_sts.print_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_dp_cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_SCHK: begin
                if (i_dp_sts.match) begin
                    if (i_dp_sts.more) begin
                        o_dp_cmd.rd_next = 1'b1;
                        n_state          = ST_SHIFT;
                    end else begin
                        o_dp_cmd.dec_count = 1'b1;
                        n_state            = ST_IDLE;
                    end
                end else if (i_dp_sts.more) begin
                    o_dp_cmd.rd_next = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                o_dp_cmd.shift_wr = 1'b1;
                if (i_dp_sts.more) begin
                    o_dp_cmd.rd_next = 1'b1;
                end else begin
                    o_dp_cmd.dec_count = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ----- sv/bdq_checker.sv -----
// bdq_checker: port-level checks on the deque unit, bound to the top level.
// Depends on bdq_pkg and bounded_deque_with_delete_by_value_unit.
module bdq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic [bdq_pkg::CMD_W-1:0]           i_cmd,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [bdq_pkg::VALUE_W-1:0]  o_out_value,
    input logic                                o_run_last,
    input logic                                o_no_element,
    input logic                                o_overflow
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_value)
            && $stable(o_run_last) && $stable(o_no_element) && $stable(o_overflow))
        else $error("stalled result changed");

    // an empty or dropped-add result is always the end of its run
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_element |-> o_run_last && (o_out_value == '0))
        else $error("no-element result not final or non-zero");

    a_ovf_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_no_element)
        else $error("overflow flagged on an element result");

    // every print gives at least one result, so the input must be held off
    a_print_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_cmd == bdq_pkg::CMD_PRINT_ALL
            || i_cmd == bdq_pkg::CMD_PRINT_FIRST || i_cmd == bdq_pkg::CMD_PRINT_LAST)
        |=> o_in_stall)
        else $error("input taken while a print run is pending");

endmodule

bind bounded_deque_with_delete_by_value_unit bdq_checker u_bdq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_cmd        (i_cmd),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_value  (o_out_value),
    .o_run_last   (o_run_last),
    .o_no_element (o_no_element),
    .o_overflow   (o_overflow)
);
